>>> rtl/bufe_pkg.sv
// shared types and constants for the buffered uart fifo engine
package bufe_pkg;

  localparam int MODE_W = 3;
  localparam int BYTE_W = 8;

  localparam logic [MODE_W-1:0] MODE_HOST_WRITE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HOST_READ  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LINE_RX    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TX_READY   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_ALL   = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic              holder_free;
  } bufe_item_t;

  typedef struct packed {
    logic              line_valid;
    logic [BYTE_W-1:0] line_byte;
    logic              accepted;
    logic              read_valid;
    logic [BYTE_W-1:0] host_byte;
    logic              rx_overflow;
    logic              rx_pending;
    logic              last;
  } bufe_result_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic dump_start;
    logic dump_read;
    logic dump_emit;
  } bufe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic dump_go;
    logic dump_last;
  } bufe_status_t;

endpackage

>>> rtl/bufe_if.sv
// request and response channel interfaces
interface bufe_req_if;
  logic                      valid;
  logic                      ready;
  logic [bufe_pkg::MODE_W-1:0] mode;
  logic [bufe_pkg::BYTE_W-1:0] data_byte;
  logic                      holder_free;

  modport source (output valid, output mode, output data_byte, output holder_free,
                  input ready);
  modport sink (input valid, input mode, input data_byte, input holder_free,
                output ready);
endinterface

interface bufe_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      line_valid;
  logic [bufe_pkg::BYTE_W-1:0] line_byte;
  logic                      accepted;
  logic                      read_valid;
  logic [bufe_pkg::BYTE_W-1:0] host_byte;
  logic                      rx_overflow;
  logic                      rx_pending;
  logic                      last;

  modport source (output valid, output line_valid, output line_byte, output accepted,
                  output read_valid, output host_byte, output rx_overflow,
                  output rx_pending, output last, input ready);
  modport sink (input valid, input line_valid, input line_byte, input accepted,
                input read_valid, input host_byte, input rx_overflow,
                input rx_pending, input last, output ready);
endinterface

>>> rtl/buffered_uart_fifo_engine_unit.sv
// top level of the buffered uart fifo engine
//
// usage
//   req carries one command transaction: mode, data_byte and holder_free
//   rsp returns result transactions; every command gives exactly one,
//   except read all, which gives one per stored receive byte (at least one)
//   the final result of a command has last set
// sequencing
//   a single-byte command is captured, then executed once the output
//   register is free, which loads its result there; the unit then returns
//   to idle and takes the next command
//   read all streams the stored bytes through alternating read and emit
//   steps, set by the single registered read port of the receive store
// reset
//   synchronous rst empties the transmit ring and receive store pointers,
//   turns draining off and drops any pending result; stored bytes are not
//   cleared and need no clearing pass
// stalls
//   a result waits in the output register until rsp.ready; a new command
//   is still taken meanwhile, and its result waits until the register frees
module buffered_uart_fifo_engine_unit #(
  parameter int BUFFER_DEPTH = 64
) (
  input logic    clk,
  input logic    rst,
  bufe_req_if.sink   req,
  bufe_rsp_if.source rsp
);
  import bufe_pkg::*;

  bufe_item_t   item;
  bufe_cmd_t    cmd;
  bufe_status_t status;
  bufe_result_t result;

  // pack the incoming transaction payload
  assign item.mode        = req.mode;
  assign item.data_byte   = req.data_byte;
  assign item.holder_free = req.holder_free;

  // sequencer decides when each step commits
  bufe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage, pointers and the output register
  bufe_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .result    (result)
  );

  // unpack the result transaction
  assign rsp.line_valid  = result.line_valid;
  assign rsp.line_byte   = result.line_byte;
  assign rsp.accepted    = result.accepted;
  assign rsp.read_valid  = result.read_valid;
  assign rsp.host_byte   = result.host_byte;
  assign rsp.rx_overflow = result.rx_overflow;
  assign rsp.rx_pending  = result.rx_pending;
  assign rsp.last        = result.last;

endmodule

>>> rtl/bufe_ctrl.sv
// sequencing state machine for the buffered uart fifo engine
module bufe_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bufe_pkg::bufe_status_t status,
  output bufe_pkg::bufe_cmd_t    cmd
);
  import bufe_pkg::*;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_EXEC     = 2'd1;
  localparam logic [1:0] ST_DUMP_RD  = 2'd2;
  localparam logic [1:0] ST_DUMP_OUT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.dump_go) begin
          cmd.dump_start = 1'b1;
          state_next     = ST_DUMP_RD;
        end else if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        cmd.dump_read = 1'b1;
        state_next    = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        if (status.out_free) begin
          cmd.dump_emit = 1'b1;
          state_next    = status.dump_last ? ST_IDLE : ST_DUMP_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/bufe_dp.sv
// datapath: transmit ring, receive store, pointers and result register
module bufe_dp #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bufe_pkg::bufe_item_t   item,
  input  bufe_pkg::bufe_cmd_t    cmd,
  output bufe_pkg::bufe_status_t status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bufe_pkg::bufe_result_t result
);
  import bufe_pkg::*;

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

  logic [BYTE_W-1:0] tx_ring [BUFFER_DEPTH];
  logic [BYTE_W-1:0] rx_store [BUFFER_DEPTH];

  bufe_item_t        cur;
  logic [BYTE_W-1:0] tx_rd_q;
  logic [BYTE_W-1:0] rx_rd_q;

  logic [IDX_W-1:0] tx_head;
  logic [IDX_W-1:0] tx_tail;
  logic             drain_enabled;
  logic [CNT_W-1:0] rx_count;
  logic [CNT_W-1:0] rx_read_pos;
  logic [CNT_W-1:0] dump_idx;

  logic [IDX_W-1:0] tx_head_next;
  logic [IDX_W-1:0] tx_tail_next;
  logic             drain_enabled_next;
  logic [CNT_W-1:0] rx_count_next;
  logic [CNT_W-1:0] rx_read_pos_next;
  logic             tx_we;
  logic             rx_we;
  logic [IDX_W-1:0] rx_raddr;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_inc;
  logic [CNT_W-1:0] pos_inc;
  logic [CNT_W-1:0] dump_inc;
  bufe_result_t     step_res;
  bufe_result_t     dump_res;

  assign head_inc = (tx_head == IDX_LAST) ? '0 : tx_head + IDX_W'(1);
  assign tail_inc = (tx_tail == IDX_LAST) ? '0 : tx_tail + IDX_W'(1);
  assign pos_inc  = rx_read_pos + CNT_W'(1);
  assign dump_inc = dump_idx + CNT_W'(1);

  assign status.out_free  = !out_valid || out_ready;
  assign status.dump_go   = (cur.mode == MODE_READ_ALL) && (rx_count != '0);
  assign status.dump_last = (dump_inc == rx_count);

  // single step outcome and next state
  always_comb begin
    tx_head_next       = tx_head;
    tx_tail_next       = tx_tail;
    drain_enabled_next = drain_enabled;
    rx_count_next      = rx_count;
    rx_read_pos_next   = rx_read_pos;
    tx_we              = 1'b0;
    rx_we              = 1'b0;
    step_res           = '0;
    case (cur.mode)
      MODE_HOST_WRITE: begin
        if ((tx_head == tx_tail) && cur.holder_free) begin
          step_res.line_valid = 1'b1;
          step_res.line_byte  = cur.data_byte;
          step_res.accepted   = 1'b1;
        end else if (head_inc != tx_tail) begin
          tx_we               = 1'b1;
          tx_head_next        = head_inc;
          drain_enabled_next  = 1'b1;
          step_res.accepted   = 1'b1;
        end
      end
      MODE_HOST_READ: begin
        if ((rx_count != '0) && (rx_read_pos < rx_count)) begin
          step_res.read_valid = 1'b1;
          step_res.host_byte  = rx_rd_q;
          rx_read_pos_next    = pos_inc;
          if (pos_inc == rx_count) begin
            rx_count_next    = '0;
            rx_read_pos_next = '0;
          end
        end
      end
      MODE_LINE_RX: begin
        if (rx_count < CNT_FULL) begin
          rx_we         = 1'b1;
          rx_count_next = rx_count + CNT_W'(1);
        end else begin
          step_res.rx_overflow = 1'b1;
        end
      end
      MODE_TX_READY: begin
        if (drain_enabled) begin
          if (tx_head != tx_tail) begin
            step_res.line_valid = 1'b1;
            step_res.line_byte  = tx_rd_q;
            tx_tail_next        = tail_inc;
            if (tx_head == tail_inc) begin
              drain_enabled_next = 1'b0;
            end
          end else begin
            drain_enabled_next = 1'b0;
          end
        end
      end
      MODE_READ_ALL: begin
        // only reached with an empty store
        rx_count_next    = '0;
        rx_read_pos_next = '0;
      end
      default: begin
      end
    endcase
    step_res.rx_pending = (rx_count_next != '0);
    step_res.last       = 1'b1;
  end

  // one streamed byte of a read all
  always_comb begin
    dump_res            = '0;
    dump_res.read_valid = 1'b1;
    dump_res.host_byte  = rx_rd_q;
    dump_res.last       = status.dump_last;
  end

  assign rx_raddr = cmd.dump_read ? dump_idx[IDX_W-1:0] : rx_read_pos[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur     <= item;
      tx_rd_q <= tx_ring[tx_tail];
    end
    if (cmd.capture || cmd.dump_read) begin
      rx_rd_q <= rx_store[rx_raddr];
    end
    if (cmd.exec && tx_we) begin
      tx_ring[tx_head] <= cur.data_byte;
    end
    if (cmd.exec && rx_we) begin
      rx_store[rx_count[IDX_W-1:0]] <= cur.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head       <= '0;
      tx_tail       <= '0;
      drain_enabled <= 1'b0;
      rx_count      <= '0;
      rx_read_pos   <= '0;
      dump_idx      <= '0;
    end else if (cmd.exec) begin
      tx_head       <= tx_head_next;
      tx_tail       <= tx_tail_next;
      drain_enabled <= drain_enabled_next;
      rx_count      <= rx_count_next;
      rx_read_pos   <= rx_read_pos_next;
    end else if (cmd.dump_start) begin
      dump_idx <= '0;
    end else if (cmd.dump_emit) begin
      dump_idx <= dump_inc;
      if (status.dump_last) begin
        rx_count    <= '0;
        rx_read_pos <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.dump_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= step_res;
    end else if (cmd.dump_emit) begin
      result <= dump_res;
    end
  end

endmodule
